>>> hdl/dpsr_pkg.sv
// Shared types, widths and constants of the Drucker-Prager stress return block.
`timescale 1ns / 1ps
package dpsr_pkg;

    localparam int SW       = 48;             // stress component, signed Q32.16
    localparam int CCFW     = 47;             // cohesion * cos(friction), unsigned Q31.16
    localparam int SINW     = 17;             // sin(friction), Q1.16
    localparam int CFGW     = 17;             // relaxation weight, Q1.16
    localparam int NCOMP    = 6;
    localparam int DW       = 50;             // deviatoric component, signed
    localparam int MW       = 49;             // multiplier a operand
    localparam int CKW      = 17;             // multiplier b chunk
    localparam int BW       = 3 * CKW;        // b operand before chunking
    localparam int PW       = MW + CKW;       // product width
    localparam int AW       = 100;            // accumulator / radicand
    localparam int TW       = 51;             // tau and divisor
    localparam int RW       = TW + 1;         // divider remainder
    localparam int SRW      = 53;             // square-root remainder
    localparam int QW       = 33;             // ratio and g
    localparam int LW       = 49;             // yield limit
    localparam int DIVN     = 50;             // divider dividend shift register
    localparam int RATIO_STEPS = 32;
    localparam int SQRT_STEPS  = AW / 2;
    localparam int CNTW     = 6;
    localparam int IN_TDATA_W  = 352;
    localparam int OUT_TDATA_W = 296;
    localparam int MEAN_SHIFT  = 51;          // (|sum|+1)/3 = ((|sum|+1)*RECIP3) >> 51

    localparam logic [CFGW-1:0] ONE_Q16   = 17'd65536;
    localparam logic [CFGW-1:0] CFG_RESET = '0;
    localparam logic [BW-1:0]   RECIP3    = 51'd750599937895083;  // (2^51 + 1) / 3
    localparam logic [2:0]      LAST_IDX  = 3'd5;
    localparam logic [2:0]      FIRST_SHEAR = 3'd3;
    localparam logic [1:0]      SQ_LAST_CHK = 2'd2;
    localparam logic [1:0]      MEAN_LAST_CHK = 2'd2;
    localparam logic [1:0]      G_LAST_CHK  = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_SUM, S_MMUL, S_MWAIT, S_MEAN, S_LMUL, S_LWAIT, S_LIM,
        S_SQ, S_SQWAIT, S_SQRT_INIT, S_SQRT, S_TAU, S_RDIV_INIT, S_RDIV,
        S_QRND, S_GMUL, S_GWAIT, S_GST, S_CMUL, S_CWAIT, S_CST, S_DONE
    } t_state;

    typedef enum logic [1:0] {A_MEAN, A_D, A_Q, A_N} t_asel;
    typedef enum logic [2:0] {B_SIN, B_D, B_W, B_G, B_R3} t_bsel;

    typedef struct packed {
        logic       load;
        logic       sum_en;
        logic       div_step;
        logic       mean_en;
        logic       d_en;
        logic       mac_clr;
        logic       mac_go;
        t_asel      asel;
        t_bsel      bsel;
        logic [1:0] chunk;
        logic       dbl;
        logic [2:0] idx;
        logic       lim_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       tau_en;
        logic       rdiv_init;
        logic       q_en;
        logic       g_en;
        logic       corr_en;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic yield;
    } t_stat;

endpackage

>>> hdl/dpsr_dpath.sv
// Datapath: operand registers, bit-serial divider and square root, shared multiply-accumulate.
`timescale 1ns / 1ps
module dpsr_dpath
    import dpsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    input  logic                   i_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFGW-1:0]        i_cfg_wdata,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    logic        [CFGW-1:0] r_w;
    logic signed [SW-1:0]   r_s [NCOMP];
    logic        [CCFW-1:0] r_ccf;
    logic        [SINW-1:0] r_sin;
    logic                   r_last;
    logic signed [DW-1:0]   r_sum;
    logic signed [LW-1:0]   r_mean;
    logic signed [DW-1:0]   r_d [NCOMP];
    logic        [RW-1:0]   r_drem;
    logic        [DIVN-1:0] r_dnum;
    logic        [TW-1:0]   r_ddiv;
    logic        [DIVN-1:0] r_quo;
    logic        [PW-1:0]   r_prod;
    logic        [5:0]      r_psh;
    logic                   r_pvld;
    logic        [AW-1:0]   r_acc;
    logic        [AW-1:0]   r_sv;
    logic        [SRW-1:0]  r_srem;
    logic        [TW-1:0]   r_root;
    logic        [TW-1:0]   r_tau;
    logic        [LW-1:0]   r_lim;
    logic                   r_yield;
    logic                   r_any;
    logic        [QW-1:0]   r_q;
    logic        [QW-1:0]   r_g;
    logic        [SW-1:0]   r_corr [NCOMP];
    logic [OUT_TDATA_W-1:0] r_out;
    logic                   r_out_last;

    function automatic logic [MW-1:0] mag_d(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(-v) : DW'(v);
        return m[MW-1:0];
    endfunction

    // operand selection for the shared multiplier
    logic signed [DW-1:0] d_sel;
    logic [MW-1:0]        a_op;
    logic [BW-1:0]        b_op;
    logic [CKW-1:0]       b_chk;
    logic [DW-1:0]        sum_abs;
    logic [LW-1:0]        mean_abs;

    assign d_sel    = r_d[i_cmd.idx];
    assign sum_abs  = r_sum[DW-1] ? DW'(-r_sum) : DW'(r_sum);
    assign mean_abs = r_mean[LW-1] ? LW'(-r_mean) : LW'(r_mean);

    always_comb begin
        case (i_cmd.asel)
            A_MEAN:  a_op = MW'(mean_abs);
            A_D:     a_op = mag_d(d_sel);
            A_Q:     a_op = MW'(r_q);
            A_N:     a_op = MW'(sum_abs + DW'(1));
            default: a_op = '0;
        endcase
        case (i_cmd.bsel)
            B_SIN:   b_op = BW'(r_sin);
            B_D:     b_op = BW'(mag_d(d_sel));
            B_W:     b_op = BW'(r_w);
            B_G:     b_op = BW'(r_g);
            B_R3:    b_op = RECIP3;
            default: b_op = '0;
        endcase
        b_chk = b_op[CKW*i_cmd.chunk +: CKW];
    end

    // divider step for the tau ratio
    logic [RW:0]   div_t;
    logic          div_ge;
    assign div_t  = {r_drem, r_dnum[DIVN-1]};
    assign div_ge = div_t >= (RW+1)'(r_ddiv);

    // square-root step, two radicand bits a step
    logic [SRW+1:0] sq_t;
    logic [SRW+1:0] sq_trial;
    logic           sq_ge;
    assign sq_t     = {r_srem, r_sv[AW-1 -: 2]};
    assign sq_trial = (SRW+2)'({r_root, 2'b01});
    assign sq_ge    = sq_t >= sq_trial;

    // yield limit from the rounded mean * sin product
    logic [AW-1:0]        lim_p;
    logic signed [LW+1:0] lim_t;
    assign lim_p = r_acc + AW'(32768);
    assign lim_t = r_mean[LW-1] ? (LW+2)'(r_ccf) + (LW+2)'(lim_p[16 +: SW])
                                : (LW+2)'(r_ccf) - (LW+2)'(lim_p[16 +: SW]);

    // correction: round the magnitude, give it the sign of -d, saturate
    logic [AW-1:0]    cr_p;
    logic [AW-33:0]   cr_m;
    logic [SW-1:0]    cr_v;
    localparam logic [AW-33:0] MAX48 = (AW-32)'({1'b0, {(SW-1){1'b1}}});
    assign cr_p = r_acc + (AW'(1) << 31);
    assign cr_m = cr_p[AW-1:32];
    always_comb begin
        if (d_sel[DW-1]) begin
            cr_v = (cr_m > MAX48) ? {1'b0, {(SW-1){1'b1}}} : cr_m[SW-1:0];
        end else begin
            cr_v = (cr_m > MAX48 + 1'b1) ? {1'b1, {(SW-1){1'b0}}} : SW'(-cr_m[SW-1:0]);
        end
    end

    assign o_stat.yield = r_tau > TW'(r_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= CFG_RESET;
            r_any  <= 1'b0;
            r_pvld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_w <= (i_cfg_wdata > ONE_Q16) ? ONE_Q16 : i_cfg_wdata;
            end
            r_pvld <= i_cmd.mac_go;
            if (i_cmd.out_load) begin
                r_any <= r_last ? 1'b0 : (r_any | r_yield);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_s[i] <= i_tdata[SW*i +: SW];
            end
            r_ccf  <= i_tdata[SW*NCOMP +: CCFW];
            r_sin  <= (i_tdata[SW*NCOMP+CCFW +: SINW] > ONE_Q16) ? ONE_Q16
                                                              : i_tdata[SW*NCOMP+CCFW +: SINW];
            r_last <= i_tlast;
        end
        if (i_cmd.sum_en) begin
            r_sum <= DW'(r_s[0]) + DW'(r_s[1]) + DW'(r_s[2]);
        end
        if (i_cmd.rdiv_init) begin
            r_drem <= RW'(r_tau - TW'(r_lim));
            r_dnum <= '0;
            r_ddiv <= r_tau;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= div_ge ? RW'(div_t - (RW+1)'(r_ddiv)) : RW'(div_t);
            r_quo  <= {r_quo[DIVN-2:0], div_ge};
            r_dnum <= {r_dnum[DIVN-2:0], 1'b0};
        end
        // signed mean from the reciprocal product of (|sum| + 1) and 1/3, with the sign of the sum
        if (i_cmd.mean_en) begin
            r_mean <= r_sum[DW-1] ? -$signed({1'b0, r_acc[MEAN_SHIFT +: SW]})
                                  : $signed({1'b0, r_acc[MEAN_SHIFT +: SW]});
        end
        if (i_cmd.d_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= DW'(r_s[i]) - DW'(r_mean);
            end
            for (int i = 3; i < NCOMP; i++) begin
                r_d[i] <= DW'(r_s[i]);
            end
        end
        if (i_cmd.mac_go) begin
            r_prod <= a_op * b_chk;
            r_psh  <= ({4'b0, i_cmd.chunk} * 6'(CKW)) + {5'b0, i_cmd.dbl};
        end
        if (i_cmd.mac_clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + (AW'(r_prod) << r_psh);
        end
        if (i_cmd.lim_en) begin
            r_lim <= lim_t[LW+1] ? '0 : lim_t[LW-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_sv   <= r_acc >> 1;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= sq_ge ? SRW'(sq_t - sq_trial) : SRW'(sq_t);
            r_root <= {r_root[TW-2:0], sq_ge};
            r_sv   <= {r_sv[AW-3:0], 2'b00};
        end
        if (i_cmd.tau_en) begin
            r_tau <= r_root + TW'(r_srem > SRW'(r_root));
        end
        if (i_cmd.rdiv_init) begin
            r_yield <= o_stat.yield;
        end
        if (i_cmd.q_en) begin
            r_q <= QW'(r_quo[RATIO_STEPS-1:0]) + QW'({r_drem, 1'b0} >= (RW+1)'(r_ddiv));
        end
        if (i_cmd.g_en) begin
            r_g <= lim_p[16 +: QW];
        end
        if (i_cmd.corr_en) begin
            r_corr[i_cmd.idx] <= cr_v;
        end
        if (i_cmd.out_load) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_out[SW*i +: SW] <= r_yield ? r_corr[i] : '0;
            end
            r_out[SW*NCOMP]                     <= r_yield;
            r_out[SW*NCOMP+1]                   <= r_last & (r_any | r_yield);
            r_out[OUT_TDATA_W-1:SW*NCOMP+2]     <= '0;
            r_out_last                          <= r_last;
        end
    end

    assign o_tdata = r_out;
    assign o_tlast = r_out_last;

endmodule

>>> hdl/dpsr_ctrl.sv
// Controller: sequences the datapath through one node and runs both stream handshakes.
`timescale 1ns / 1ps
module dpsr_ctrl
    import dpsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [2:0]      r_idx, n_idx;
    logic [1:0]      r_chk, n_chk;
    logic            r_ovld, n_ovld;
    logic            can_load;

    assign can_load = !r_ovld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_chk   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
            r_ovld  <= n_ovld;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_chk   = r_chk;
        n_ovld  = r_ovld && !i_out_ready;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SUM;
            S_SUM:       n_state = S_MMUL;
            S_MMUL: begin
                n_chk = r_chk + 1'b1;
                if (r_chk == MEAN_LAST_CHK) begin
                    n_chk   = '0;
                    n_state = S_MWAIT;
                end
            end
            S_MWAIT:     n_state = S_MEAN;
            S_MEAN:      n_state = S_LMUL;
            S_LMUL:      n_state = S_LWAIT;
            S_LWAIT:     n_state = S_LIM;
            S_LIM:       n_state = S_SQ;
            S_SQ: begin
                n_chk = r_chk + 1'b1;
                if (r_chk == SQ_LAST_CHK) begin
                    n_chk = '0;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_SQWAIT;
                    end
                end
            end
            S_SQWAIT:    n_state = S_SQRT_INIT;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_TAU;
                end
            end
            S_TAU:       n_state = S_RDIV_INIT;
            S_RDIV_INIT: n_state = i_stat.yield ? S_RDIV : S_DONE;
            S_RDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(RATIO_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_QRND;
                end
            end
            S_QRND:      n_state = S_GMUL;
            S_GMUL:      n_state = S_GWAIT;
            S_GWAIT:     n_state = S_GST;
            S_GST:       n_state = S_CMUL;
            S_CMUL: begin
                n_chk = r_chk + 1'b1;
                if (r_chk == G_LAST_CHK) begin
                    n_chk   = '0;
                    n_state = S_CWAIT;
                end
            end
            S_CWAIT:     n_state = S_CST;
            S_CST: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_CMUL;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (can_load) begin
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.asel  = A_D;
        o_cmd.bsel  = B_D;
        o_cmd.chunk = r_chk;
        o_cmd.idx   = r_idx;
        o_cmd.dbl   = r_idx >= FIRST_SHEAR;
        case (r_state)
            S_IDLE:      o_cmd.load      = i_in_valid;
            S_SUM: begin
                o_cmd.sum_en  = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_MMUL: begin
                o_cmd.mac_go = 1'b1;
                o_cmd.asel   = A_N;
                o_cmd.bsel   = B_R3;
                o_cmd.dbl    = 1'b0;
            end
            S_MEAN: begin
                o_cmd.mean_en = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_LMUL: begin
                o_cmd.d_en   = 1'b1;
                o_cmd.mac_go = 1'b1;
                o_cmd.asel   = A_MEAN;
                o_cmd.bsel   = B_SIN;
                o_cmd.chunk  = '0;
                o_cmd.dbl    = 1'b0;
            end
            S_LIM: begin
                o_cmd.lim_en  = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_SQ:        o_cmd.mac_go    = 1'b1;
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                o_cmd.mac_clr   = 1'b1;
            end
            S_SQRT:      o_cmd.sqrt_step = 1'b1;
            S_TAU:       o_cmd.tau_en    = 1'b1;
            S_RDIV_INIT: o_cmd.rdiv_init = 1'b1;
            S_RDIV:      o_cmd.div_step  = 1'b1;
            S_QRND: begin
                o_cmd.q_en    = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_GMUL: begin
                o_cmd.mac_go = 1'b1;
                o_cmd.asel   = A_Q;
                o_cmd.bsel   = B_W;
                o_cmd.chunk  = '0;
                o_cmd.dbl    = 1'b0;
            end
            S_GST: begin
                o_cmd.g_en    = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_CMUL: begin
                o_cmd.mac_go = 1'b1;
                o_cmd.bsel   = B_G;
                o_cmd.dbl    = 1'b0;
            end
            S_CST: begin
                o_cmd.corr_en = 1'b1;
                o_cmd.mac_clr = 1'b1;
            end
            S_DONE:      o_cmd.out_load  = can_load;
            default:     o_cmd.load      = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

>>> hdl/drucker_prager_stress_return.sv
// Top level of the Drucker-Prager plastic stress return block.
`timescale 1ns / 1ps
// Drucker-Prager return mapping, one nodal stress tensor per item. Each item
// gives the six Q32.16 stress components with the element's cohesion*cos
// and sin of the friction angle; the block forms mean and deviatoric stress,
// tau, the yield limit (clamped at zero) and, for a yielding node, the
// correction -d*(1 - limit/tau)*weight, rounded and saturated to 48 bits.
// Nodes are worked one at a time; an elastic node skips the divider and
// the corrections. The mean is a reciprocal multiply by 1/3 (3 passes),
// the ratio (tau - limit)/tau runs on a bit-serial divider (32 steps), tau
// on a two-bits-a-step square root (50 steps), and all products on one
// shared 49x17 multiply-accumulate (18 passes for tau squared, 12 for the
// corrections). A finished result sits in the output register, so the next
// item is taken while it waits. element_adjusted is the OR of node_yielded
// over the element, shown on the node marked tlast and cleared after it.
// The weight register is to be written with i_cfg_we only while no item is
// in flight; the block does not enforce this. Values above one act as one.
module drucker_prager_stress_return
    import dpsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFGW-1:0]        i_cfg_wdata,   // one_minus_integrating_factor
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz,
    // cohesion_cos_friction, sin_friction
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,  // last_node
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // corr_xx, corr_yy, corr_zz, corr_xy, corr_yz, corr_xz,
    // node_yielded, element_adjusted, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast   // end_of_element
);

    t_cmd  cmd;
    t_stat stat;

    dpsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dpsr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tdata     (s_axis_tdata),
        .i_tlast     (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule

>>> hdl/dpsr_checker.sv
// Port-level checks of the stress return block, bound to its top level.
`timescale 1ns / 1ps
module dpsr_checker
    import dpsr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    localparam int YB = SW * NCOMP;

    // element flag only on the closing node
    a_adj_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[YB+1] |-> m_axis_tlast)
        else $error("element_adjusted outside the last node");

    // a yielding last node must flag its element
    a_adj_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[YB] |-> m_axis_tdata[YB+1])
        else $error("yielding last node without element_adjusted");

    // elastic node carries no correction
    a_elastic_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[YB] |-> m_axis_tdata[YB-1:0] == '0)
        else $error("correction on an elastic node");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

endmodule

bind drucker_prager_stress_return dpsr_checker u_dpsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> sim/testbench.sv
// Self-checking testbench for the Drucker-Prager stress return block.
`timescale 1ns / 1ps

// Keeps the expected corrections of accepted nodes and checks each result in order.
class return_scoreboard;
    typedef struct {
        logic [47:0] corr[6];
        logic        yielded;
        logic        adjusted;
        logic        eoe;
    } t_expect;

    t_expect     pending[$];
    logic [16:0] weight;
    bit          any_yield;
    int          errors;

    function new();
        weight    = '0;
        any_yield = 0;
        errors    = 0;
    endfunction

    function void set_weight(logic [16:0] w);
        weight = w;
    endfunction

    function automatic void report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endfunction

    // Integer square root of a 100-bit radicand, rounded to nearest.
    function automatic logic [50:0] root_round(logic [99:0] v);
        logic [50:0] r;
        logic [50:0] c;
        logic [101:0] sq;
        r = '0;
        for (int b = 49; b >= 0; b--) begin
            c  = r | (51'd1 << b);
            sq = c * c;
            if (sq <= v) r = c;
        end
        sq = r * (r + 1);
        if (v > sq) r = r + 1;
        return r;
    endfunction

    // -d*g, magnitude rounded half away from zero, saturated to 48 bits.
    function automatic logic [47:0] scale_corr(logic signed [49:0] d, logic [32:0] g);
        logic [49:0] m;
        logic [83:0] p;
        logic [51:0] q;
        logic signed [51:0] c;
        m = d < 0 ? -d : d;
        p = m * g + (84'd1 << 31);
        q = p >> 32;
        if (d < 0) c = q > 52'h7FFFFFFFFFFF ? 52'sh7FFFFFFFFFFF : $signed(q);
        else       c = q > 52'h800000000000 ? -52'sh800000000000 : -$signed(q);
        return c[47:0];
    endfunction

    function void note_node(logic signed [47:0] s[6], logic [46:0] ccf,
                            logic [16:0] sinf, bit last);
        t_expect e;
        logic signed [51:0] sum, mean, taulim;
        logic [51:0] am, prod, tau, rem;
        logic signed [49:0] d[6];
        logic [99:0] diag, shear;
        logic [49:0] m;
        logic [32:0] q, g, w;
        logic [68:0] pw;
        logic [65:0] gw;
        bit yld;
        if (sinf > 17'd65536) sinf = 17'd65536;
        sum  = s[0] + s[1] + s[2];
        am   = ((sum < 0 ? -sum : sum) + 1) / 3;
        mean = sum < 0 ? -$signed(am) : $signed(am);
        for (int i = 0; i < 6; i++) d[i] = i < 3 ? s[i] - mean : s[i];
        diag  = '0;
        shear = '0;
        for (int i = 0; i < 6; i++) begin
            m = d[i] < 0 ? -d[i] : d[i];
            if (i < 3) diag += m * m;
            else       shear += m * m;
        end
        tau    = root_round((diag >> 1) + shear);
        pw     = 69'(mean < 0 ? -mean : mean) * 69'(sinf) + 69'd32768;
        prod   = 52'(pw >> 16);
        taulim = $signed({5'd0, ccf}) - (mean < 0 ? -$signed(prod) : $signed(prod));
        if (taulim < 0) taulim = 0;
        yld = tau > taulim;
        g   = '0;
        if (yld) begin
            rem = tau - taulim;
            q   = '0;
            for (int i = 0; i < 32; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= tau) begin
                    rem -= tau;
                    q[0] = 1'b1;
                end
            end
            if ((rem << 1) >= tau) q++;
            w  = weight > 17'd65536 ? 33'd65536 : 33'(weight);
            gw = 66'(q) * 66'(w) + 66'd32768;
            g  = 33'(gw >> 16);
        end
        for (int i = 0; i < 6; i++) e.corr[i] = yld ? scale_corr(d[i], g) : '0;
        any_yield  = any_yield | yld;
        e.yielded  = yld;
        e.adjusted = last & any_yield;
        e.eoe      = last;
        if (last) any_yield = 0;
        pending.push_back(e);
    endfunction

    function void check_result(logic [295:0] data, logic tlast);
        t_expect e;
        if (pending.size() == 0) begin
            report("result with nothing expected");
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 6; i++)
            if (data[48*i +: 48] !== e.corr[i])
                report($sformatf("corr[%0d] got %h exp %h", i, data[48*i +: 48], e.corr[i]));
        if (data[288] !== e.yielded)  report("node_yielded");
        if (data[289] !== e.adjusted) report("element_adjusted");
        if (tlast !== e.eoe)          report("end_of_element");
    endfunction
endclass

module testbench;
    import dpsr_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFGW-1:0]        i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // xx, yy, zz, xy, yz, xz, ccf, sin
    logic                   s_axis_tlast;   // last_node
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // corr xx..xz, yielded, adjusted
    logic                   m_axis_tlast;   // end_of_element

    return_scoreboard sb;
    int  cycles;
    bit  calm;          // no idling on either side
    localparam int CYCLE_LIMIT = 1500000;

    drucker_prager_stress_return DUT (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stalls, checking on every accepted item.
    initial m_axis_tready = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [47:0] rand_stress(int mode);
        case (mode)
            0: return 48'({$urandom, $urandom});
            1: return 48'($signed($urandom_range(2000000)) - 1000000) <<< 8;
            default: return 48'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    // tvalid stays high into the next item unless that item starts with idling
    task automatic send_node(logic [47:0] s[6], logic [46:0] ccf, logic [16:0] sinf,
                             bit last);
        logic signed [47:0] ss[6];
        if (!calm && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < 32);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {sinf, ccf, s[5], s[4], s[3], s[2], s[1], s[0]};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        foreach (ss[i]) ss[i] = s[i];
        sb.note_node(ss, ccf, sinf, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [16:0] w);
        i_cfg_we    <= 1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        sb.set_weight(w);
    endtask

    task automatic random_nodes(int count);
        logic [47:0] s[6];
        logic [46:0] ccf;
        logic [16:0] sinf;
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(2);
            foreach (s[i]) s[i] = rand_stress(mode);
            case ($urandom_range(3))
                0: ccf = 47'({$urandom, $urandom});
                1: ccf = '0;
                default: ccf = 47'($urandom_range(mode == 2 ? 200000 : 100000000));
            endcase
            sinf = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
            send_node(s, ccf, sinf, $urandom_range(3) == 0);
        end
    endtask

    initial begin
        logic [47:0] s[6];
        logic [16:0] weights[5];
        weights       = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'd1};
        sb            = new();
        cycles        = 0;
        calm          = 0;
        i_rst_n       = 0;
        i_cfg_we      = 0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, weight above one, elastic node, clamped limit, sine above one
        write_weight(17'd65536);
        foreach (s[i]) s[i] = 48'h7FFFFFFFFFFF;
        send_node(s, '0, 17'd0, 0);
        foreach (s[i]) s[i] = 48'h800000000000;
        send_node(s, 47'h7FFFFFFFFFFF, 17'h1FFFF, 1);
        foreach (s[i]) s[i] = i[0] ? 48'h7FFFFFFFFFFF : 48'h800000000000;
        send_node(s, '0, 17'd65536, 0);
        foreach (s[i]) s[i] = '0;
        send_node(s, '0, 17'd0, 1);
        s = '{48'd1000000, 48'd0, -48'd1000000, 48'd5000, 48'd0, 48'd0};
        send_node(s, 47'd100, 17'd30000, 0);
        send_node(s, 47'h7FFFFFFFFFFF, 17'd30000, 1);
        s = '{48'd4000000, 48'd4000000, 48'd4000000, 48'd9, 48'd0, 48'd0};
        send_node(s, 47'd10, 17'h1FFFF, 1);
        drain();
        write_weight(17'h1FFFF);
        send_node(s, 47'd10, 17'd65536, 1);
        foreach (s[i]) s[i] = 48'h800000000000;
        send_node(s, '0, 17'd0, 1);
        drain();

        // random phases over several weights, with one calm stretch
        foreach (weights[k]) begin
            write_weight(weights[k]);
            calm = (k == 3);
            random_nodes(k == 4 ? 160 : 155);
            drain();
        end
        write_weight(17'($urandom_range(65536)));
        random_nodes(20);
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/dpsr_pkg.sv
hdl/dpsr_dpath.sv
hdl/dpsr_ctrl.sv
hdl/drucker_prager_stress_return.sv
hdl/dpsr_checker.sv
sim/testbench.sv
